### design/sorted_set_kth_select_defines.svh
// Assertion macros for the checker file of the sorted set block.
`ifndef SORTED_SET_KTH_SELECT_DEFINES_SVH
`define SORTED_SET_KTH_SELECT_DEFINES_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define SSK_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// Next-cycle implication, checked on every rising clock edge outside reset.
`define SSK_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`endif

### design/ssk_pkg.sv
// Package: types, codes and constants of the sorted set k-th select block.
`timescale 1ns / 1ps
`default_nettype none

package ssk_pkg;

   localparam int CAPACITY_DEFAULT = 64;
   localparam int VALUE_W          = 32;
   localparam int RANK_W           = 7;
   localparam int OPCODE_W         = 2;

   typedef enum logic [OPCODE_W-1:0] {
      OP_INSERT   = 2'd0,
      OP_SMALLEST = 2'd1,
      OP_LARGEST  = 2'd2
   } opcode_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DECODE,
      ST_SRCH_RD,
      ST_SRCH_CMP,
      ST_INS_PREP,
      ST_SHIFT_RD,
      ST_SHIFT_WR,
      ST_INS_WRITE,
      ST_Q_DATA
   } state_type;

   typedef enum logic [1:0] {
      RSP_EMPTY,
      RSP_FOUND,
      RSP_DROPPED
   } rsp_kind_type;

   typedef struct packed {
      logic         load;
      logic         rd_query;
      logic         q_largest;
      logic         rd_mid;
      logic         narrow;
      logic         rd_shift;
      logic         wr_shift;
      logic         wr_new;
      logic         rsp_load;
      rsp_kind_type rsp_kind;
   } cmd_type;

   typedef struct packed {
      logic count_zero;
      logic full;
      logic rank_ok;
      logic cmp_eq;
      logic range_closes;
      logic at_pos;
      logic shift_last;
   } status_type;

endpackage

`default_nettype wire

### design/ssk_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
`timescale 1ns / 1ps
`default_nettype none

module ssk_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

### design/ssk_ctrl.sv
// Controller: sequences search, shift, insert and query steps over the store.
`timescale 1ns / 1ps
`default_nettype none

module ssk_ctrl (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              start,
   input  wire logic [ssk_pkg::OPCODE_W-1:0]      req_opcode,
   input  wire ssk_pkg::status_type               status,
   output logic                                   busy,
   output ssk_pkg::cmd_type                       cmd
);

   ssk_pkg::state_type  state_ff, state_in;
   ssk_pkg::opcode_type op_ff, op_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ssk_pkg::ST_IDLE;
         op_ff    <= ssk_pkg::OP_INSERT;
      end else begin
         state_ff <= state_in;
         op_ff    <= op_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      busy         = (state_ff != ssk_pkg::ST_IDLE);
      cmd          = '0;
      cmd.rsp_kind = ssk_pkg::RSP_EMPTY;
      cmd.q_largest = (op_ff == ssk_pkg::OP_LARGEST);

      unique case (state_ff)
         ssk_pkg::ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               op_in    = ssk_pkg::opcode_type'(req_opcode);
               state_in = ssk_pkg::ST_DECODE;
            end
         end
         ssk_pkg::ST_DECODE: begin
            unique case (op_ff)
               ssk_pkg::OP_INSERT: begin
                  state_in = status.count_zero ? ssk_pkg::ST_INS_PREP : ssk_pkg::ST_SRCH_RD;
               end
               ssk_pkg::OP_SMALLEST, ssk_pkg::OP_LARGEST: begin
                  if (status.rank_ok) begin
                     cmd.rd_query = 1'b1;
                     state_in     = ssk_pkg::ST_Q_DATA;
                  end else begin
                     cmd.rsp_load = 1'b1;
                     state_in     = ssk_pkg::ST_IDLE;
                  end
               end
               default: begin
                  cmd.rsp_load = 1'b1;
                  state_in     = ssk_pkg::ST_IDLE;
               end
            endcase
         end
         ssk_pkg::ST_SRCH_RD: begin
            cmd.rd_mid = 1'b1;
            state_in   = ssk_pkg::ST_SRCH_CMP;
         end
         ssk_pkg::ST_SRCH_CMP: begin
            if (status.cmp_eq) begin
               // duplicate: store stays as it is
               cmd.rsp_load = 1'b1;
               state_in     = ssk_pkg::ST_IDLE;
            end else begin
               cmd.narrow = 1'b1;
               state_in   = status.range_closes ? ssk_pkg::ST_INS_PREP : ssk_pkg::ST_SRCH_RD;
            end
         end
         ssk_pkg::ST_INS_PREP: begin
            if (status.full) begin
               cmd.rsp_load = 1'b1;
               cmd.rsp_kind = ssk_pkg::RSP_DROPPED;
               state_in     = ssk_pkg::ST_IDLE;
            end else if (status.at_pos) begin
               state_in = ssk_pkg::ST_INS_WRITE;
            end else begin
               state_in = ssk_pkg::ST_SHIFT_RD;
            end
         end
         ssk_pkg::ST_SHIFT_RD: begin
            cmd.rd_shift = 1'b1;
            state_in     = ssk_pkg::ST_SHIFT_WR;
         end
         ssk_pkg::ST_SHIFT_WR: begin
            cmd.wr_shift = 1'b1;
            state_in     = status.shift_last ? ssk_pkg::ST_INS_WRITE : ssk_pkg::ST_SHIFT_RD;
         end
         ssk_pkg::ST_INS_WRITE: begin
            cmd.wr_new   = 1'b1;
            cmd.rsp_load = 1'b1;
            state_in     = ssk_pkg::ST_IDLE;
         end
         ssk_pkg::ST_Q_DATA: begin
            cmd.rsp_load = 1'b1;
            cmd.rsp_kind = ssk_pkg::RSP_FOUND;
            state_in     = ssk_pkg::ST_IDLE;
         end
         default: begin
            state_in = ssk_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

### design/ssk_dpath.sv
// Datapath: operand registers, search bounds, shift pointer, store and result registers.
`timescale 1ns / 1ps
`default_nettype none

module ssk_dpath #(
   parameter int CAPACITY = ssk_pkg::CAPACITY_DEFAULT
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic signed [ssk_pkg::VALUE_W-1:0]  req_item_value,
   input  wire logic        [ssk_pkg::RANK_W-1:0]   req_rank,
   input  wire ssk_pkg::cmd_type                    cmd,
   output ssk_pkg::status_type                      status,
   output logic                                     rsp_valid,
   output logic signed      [ssk_pkg::VALUE_W-1:0]  rsp_result_value,
   output logic                                     rsp_found,
   output logic                                     rsp_dropped
);

   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int MW = (CW > ssk_pkg::RANK_W) ? CW : ssk_pkg::RANK_W;

   logic signed [ssk_pkg::VALUE_W-1:0] value_ff;
   logic        [ssk_pkg::RANK_W-1:0]  rank_ff;
   logic        [CW-1:0]               count_ff;
   logic        [CW-1:0]               lo_ff;
   logic        [CW-1:0]               hi_ff;
   logic        [CW-1:0]               j_ff;
   logic                               rsp_valid_ff;
   logic signed [ssk_pkg::VALUE_W-1:0] rsp_value_ff;
   logic                               rsp_found_ff;
   logic                               rsp_dropped_ff;

   logic [CW:0]                  mid_sum;
   logic [CW-1:0]                mid;
   logic [CW-1:0]                mid_inc;
   logic [CW-1:0]                j_dec;
   logic [MW-1:0]                q_index;
   logic                         stored_lt;
   logic                         ram_wr_en;
   logic [AW-1:0]                ram_wr_addr;
   logic [ssk_pkg::VALUE_W-1:0]  ram_wr_data;
   logic                         ram_rd_en;
   logic [AW-1:0]                ram_rd_addr;
   logic [ssk_pkg::VALUE_W-1:0]  ram_rd_data;

   assign mid_sum   = {1'b0, lo_ff} + {1'b0, hi_ff};
   assign mid       = mid_sum[CW:1];
   assign mid_inc   = mid + CW'(1);
   assign j_dec     = j_ff - CW'(1);
   assign stored_lt = $signed(ram_rd_data) < value_ff;
   assign q_index   = cmd.q_largest ? (MW'(count_ff) - MW'(rank_ff))
                                    : (MW'(rank_ff) - MW'(1));

   always_comb begin
      status.count_zero   = (count_ff == '0);
      status.full         = (count_ff == CW'(CAPACITY));
      status.rank_ok      = (rank_ff != '0) && (MW'(rank_ff) <= MW'(count_ff));
      status.cmp_eq       = (ram_rd_data == value_ff);
      status.range_closes = stored_lt ? (mid_inc == hi_ff) : (mid == lo_ff);
      status.at_pos       = (j_ff == lo_ff);
      status.shift_last   = (j_dec == lo_ff);
   end

   always_comb begin
      ram_rd_en   = cmd.rd_query | cmd.rd_mid | cmd.rd_shift;
      ram_rd_addr = j_dec[AW-1:0];
      if (cmd.rd_query) begin
         ram_rd_addr = q_index[AW-1:0];
      end else if (cmd.rd_mid) begin
         ram_rd_addr = mid[AW-1:0];
      end
      ram_wr_en   = cmd.wr_shift | cmd.wr_new;
      ram_wr_addr = cmd.wr_new ? lo_ff[AW-1:0] : j_ff[AW-1:0];
      ram_wr_data = cmd.wr_new ? value_ff : ram_rd_data;
   end

   ssk_ram #(
      .WIDTH (ssk_pkg::VALUE_W),
      .DEPTH (CAPACITY)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.rsp_load;
         if (cmd.wr_new) begin
            count_ff <= count_ff + CW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         value_ff <= req_item_value;
         rank_ff  <= req_rank;
         lo_ff    <= '0;
         hi_ff    <= count_ff;
         j_ff     <= count_ff;
      end else begin
         if (cmd.narrow) begin
            if (stored_lt) begin
               lo_ff <= mid_inc;
            end else begin
               hi_ff <= mid;
            end
         end
         if (cmd.wr_shift) begin
            j_ff <= j_dec;
         end
      end
      if (cmd.rsp_load) begin
         unique case (cmd.rsp_kind)
            ssk_pkg::RSP_FOUND: begin
               rsp_value_ff   <= ram_rd_data;
               rsp_found_ff   <= 1'b1;
               rsp_dropped_ff <= 1'b0;
            end
            ssk_pkg::RSP_DROPPED: begin
               rsp_value_ff   <= '0;
               rsp_found_ff   <= 1'b0;
               rsp_dropped_ff <= 1'b1;
            end
            default: begin
               rsp_value_ff   <= '0;
               rsp_found_ff   <= 1'b0;
               rsp_dropped_ff <= 1'b0;
            end
         endcase
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_value = rsp_value_ff;
   assign rsp_found        = rsp_found_ff;
   assign rsp_dropped      = rsp_dropped_ff;

endmodule

`default_nettype wire

### design/sorted_set_kth_select.sv
// Top level: order-statistic store of distinct signed values with k-th select.
//
//   channel   direction  transfer when          payload ports
//   request   in         start & !busy          req_opcode, req_item_value, req_rank
//   response  out        rsp_valid (1 cycle)    rsp_result_value, rsp_found, rsp_dropped
//
// A query reads the ranked entry; a rank of zero or above the count and the
// unused opcode answer with no read. An insert runs binary-search probes (at
// most ceil(log2(count+1))), then moves the entries above the slot up one slot;
// a duplicate ends within the search, a dropped insert after it. The single
// registered read port splits each probe and move into read and compare/write.
// Sync reset clears count, rsp_valid and FSM state; the receiver cannot stall.
`timescale 1ns / 1ps
`default_nettype none

module sorted_set_kth_select #(
   parameter int CAPACITY = ssk_pkg::CAPACITY_DEFAULT
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                start,
   output logic                                     busy,
   input  wire logic        [ssk_pkg::OPCODE_W-1:0] req_opcode,
   input  wire logic signed [ssk_pkg::VALUE_W-1:0]  req_item_value,
   input  wire logic        [ssk_pkg::RANK_W-1:0]   req_rank,
   output logic                                     rsp_valid,
   output logic signed      [ssk_pkg::VALUE_W-1:0]  rsp_result_value,
   output logic                                     rsp_found,
   output logic                                     rsp_dropped
);

   // Commands go down to the datapath, flags come back; nothing else crosses.
   ssk_pkg::cmd_type    cmd;
   ssk_pkg::status_type status;

   // Sequence each transfer: decode, search for the slot, move the upper
   // entries up by one, write the new value, or read a ranked entry.
   ssk_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_opcode (req_opcode),
      .status     (status),
      .busy       (busy),
      .cmd        (cmd)
   );

   // Hold the operands, bounds, count and the ascending value store, and
   // drive the response registers.
   ssk_dpath #(
      .CAPACITY (CAPACITY)
   ) u_dpath (
      .clock            (clock),
      .reset            (reset),
      .req_item_value   (req_item_value),
      .req_rank         (req_rank),
      .cmd              (cmd),
      .status           (status),
      .rsp_valid        (rsp_valid),
      .rsp_result_value (rsp_result_value),
      .rsp_found        (rsp_found),
      .rsp_dropped      (rsp_dropped)
   );

endmodule

`default_nettype wire

### design/ssk_checker.sv
// Port-level checker of the sorted set block and its bind to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "sorted_set_kth_select_defines.svh"

module ssk_checker (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                start,
   input  wire logic                                busy,
   input  wire logic                                rsp_valid,
   input  wire logic signed [ssk_pkg::VALUE_W-1:0]  rsp_result_value,
   input  wire logic                                rsp_found,
   input  wire logic                                rsp_dropped
);

   `SSK_ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy)
   `SSK_ASSERT_IMPLY(a_rsp_after_busy, clock, reset, rsp_valid, $past(busy))
   `SSK_ASSERT_NEXT(a_rsp_single, clock, reset, rsp_valid, !rsp_valid)
   `SSK_ASSERT_IMPLY(a_rsp_zero_value, clock, reset, rsp_valid && !rsp_found,
      rsp_result_value == '0)
   `SSK_ASSERT_IMPLY(a_rsp_flags, clock, reset, rsp_valid, !(rsp_found && rsp_dropped))

endmodule

bind sorted_set_kth_select ssk_checker u_ssk_checker (
   .clock            (clock),
   .reset            (reset),
   .start            (start),
   .busy             (busy),
   .rsp_valid        (rsp_valid),
   .rsp_result_value (rsp_result_value),
   .rsp_found        (rsp_found),
   .rsp_dropped      (rsp_dropped)
);

`default_nettype wire

### sim/tb_top.sv
// Testbench for sorted_set_kth_select: directed and random transfers checked against a shadow set.
`timescale 1ns / 1ps

module tb_top;
   import ssk_pkg::*;

   localparam int SET_CAPACITY   = CAPACITY_DEFAULT;
   localparam int RESET_CYCLES   = 11;
   // Longest insert: 6 probes and 63 moved entries.
   localparam int DRAIN_CYCLES   = 200;
   localparam int WATCHDOG_LIMIT = 1000;
   localparam int REPORT_LIMIT   = 100;

   // The package names no code for the fourth opcode; the block treats it as a no-op.
   localparam logic [OPCODE_W-1:0]       OP_UNUSED = 2'd3;
   localparam logic signed [VALUE_W-1:0] VALUE_MIN = 32'sh8000_0000;
   localparam logic signed [VALUE_W-1:0] VALUE_MAX = 32'sh7fff_ffff;

   // One response as the block should present it.
   typedef struct packed {
      logic signed [VALUE_W-1:0] value;
      logic                      found;
      logic                      dropped;
   } answer_type;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       start = 1'b0;
   logic                       busy;
   logic [OPCODE_W-1:0]        req_opcode = '0;
   logic signed [VALUE_W-1:0]  req_item_value = '0;
   logic [RANK_W-1:0]          req_rank = '0;
   logic                       rsp_valid;
   logic signed [VALUE_W-1:0]  rsp_result_value;
   logic                       rsp_found;
   logic                       rsp_dropped;

   // Shadow copy of the stored set, kept in ascending order.
   logic signed [VALUE_W-1:0]  shadow_set[$];
   // Responses owed by the block, oldest first.
   answer_type                 awaited_answers[$];

   bit sender_idles = 1'b1;
   int error_count   = 0;
   int items_sent    = 0;
   int inserts_sent  = 0;
   int found_seen    = 0;
   int dropped_seen  = 0;
   int stall_cycles  = 0;

   sorted_set_kth_select #(
      .CAPACITY(SET_CAPACITY)
   ) dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_opcode      (req_opcode),
      .req_item_value  (req_item_value),
      .req_rank        (req_rank),
      .rsp_valid       (rsp_valid),
      .rsp_result_value(rsp_result_value),
      .rsp_found       (rsp_found),
      .rsp_dropped     (rsp_dropped)
   );

   // 8 ns clock.
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Print one line per mismatch and count it; hold the log to a sane size.
   task automatic report_failure(input string what);
      error_count++;
      if (error_count <= REPORT_LIMIT) begin
         $display("[%0t ns] mismatch: %s", $time, what);
      end
   endtask

   // Apply one accepted operation to the shadow set and return the response it owes.
   // Insert: find the first entry not below the value; an equal entry means a
   // duplicate (no change, all zero), a full set means the new value is dropped.
   // Queries: rank k counts from the low end for smallest, from the high end for
   // largest; rank zero or above the count gives nothing found.
   function automatic answer_type apply_to_shadow_set(input logic [OPCODE_W-1:0] op,
         input logic signed [VALUE_W-1:0] val, input logic [RANK_W-1:0] rk);
      answer_type ans;
      int         pos;
      int         n;
      ans = '0;
      n   = shadow_set.size();
      if (op == OP_INSERT) begin
         pos = 0;
         while (pos < n && shadow_set[pos] < val) pos++;
         if (pos == n || shadow_set[pos] != val) begin
            if (n >= SET_CAPACITY) begin
               ans.dropped = 1'b1;
            end else begin
               shadow_set.insert(pos, val);
            end
         end
      end else if (op == OP_SMALLEST || op == OP_LARGEST) begin
         if (rk >= 1 && rk <= n) begin
            ans.found = 1'b1;
            ans.value = (op == OP_SMALLEST) ? shadow_set[rk - 1] : shadow_set[n - rk];
         end
      end
      return ans;
   endfunction

   // Pick a rank: mostly inside the stored count, with zero, the top rank and
   // ranks above the count up to the capacity mixed in.
   function automatic logic [RANK_W-1:0] pick_rank();
      int n;
      int roll;
      n    = shadow_set.size();
      roll = $urandom_range(0, 99);
      if (roll < 6) return '0;
      if (roll < 12) return RANK_W'(SET_CAPACITY);
      if (roll < 82 && n > 0) return RANK_W'($urandom_range(1, n));
      if (n < SET_CAPACITY) return RANK_W'($urandom_range(n + 1, SET_CAPACITY));
      return RANK_W'($urandom_range(0, SET_CAPACITY));
   endfunction

   // Pick a value: a narrow pool around zero to force duplicates, values near
   // both ends of the signed range, and full 32-bit random values.
   function automatic logic signed [VALUE_W-1:0] pick_value();
      case ($urandom_range(0, 9))
         0: return VALUE_MIN + $urandom_range(0, 3);
         1: return VALUE_MAX - $urandom_range(0, 3);
         2, 3, 4: return $signed($urandom_range(0, 40)) - 20;
         default: return $urandom;
      endcase
   endfunction

   // Send one item: optionally idle for a burst, then hold start and the
   // payload until a rising edge finds busy low. That edge is the transfer,
   // so record the owed response right there.
   task automatic send_request(input logic [OPCODE_W-1:0] op,
         input logic signed [VALUE_W-1:0] val, input logic [RANK_W-1:0] rk);
      int gap;
      gap = 0;
      if (sender_idles && $urandom_range(0, 2) == 0) gap = $urandom_range(1, 16);
      @(negedge clock);
      if (gap != 0) begin
         start <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      start          <= 1'b1;
      req_opcode     <= op;
      req_item_value <= val;
      req_rank       <= rk;
      @(posedge clock);
      while (busy) @(posedge clock);
      awaited_answers.push_back(apply_to_shadow_set(op, val, rk));
      items_sent++;
      if (op == OP_INSERT) inserts_sent++;
   endtask

   // Send one random item; unused opcodes come in as a little noise.
   task automatic send_random_item(input int insert_pct);
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 3) begin
         send_request(OP_UNUSED, $urandom, RANK_W'($urandom));
      end else if (roll < 3 + insert_pct) begin
         send_request(OP_INSERT, pick_value(), RANK_W'($urandom));
      end else begin
         send_request(($urandom_range(0, 1) != 0) ? OP_SMALLEST : OP_LARGEST,
                      $urandom, pick_rank());
      end
   endtask

   // Queries on the empty set find nothing, whatever the rank; the unused
   // opcode answers all zero.
   task automatic test_empty_store();
      send_request(OP_SMALLEST, 32'sd0, 7'd0);
      send_request(OP_SMALLEST, 32'sd5, 7'd1);
      send_request(OP_LARGEST, VALUE_MAX, 7'd1);
      send_request(OP_LARGEST, 32'sd0, RANK_W'(SET_CAPACITY));
      send_request(OP_UNUSED, 32'sd0, 7'd1);
   endtask

   // Store both ends of the signed range, zero and minus one, repeat one of
   // them, then select at both ends and just past the count.
   task automatic test_extreme_values();
      send_request(OP_INSERT, VALUE_MAX, 7'd127);
      send_request(OP_INSERT, VALUE_MIN, 7'd0);
      send_request(OP_INSERT, 32'sd0, 7'd3);
      send_request(OP_INSERT, -32'sd1, 7'd64);
      send_request(OP_INSERT, VALUE_MAX, 7'd0);
      send_request(OP_SMALLEST, 32'sd0, 7'd1);
      send_request(OP_SMALLEST, -32'sd1, 7'd4);
      send_request(OP_LARGEST, VALUE_MIN, 7'd1);
      send_request(OP_LARGEST, 32'sd0, 7'd4);
      send_request(OP_LARGEST, 32'sd0, 7'd5);
      send_request(OP_SMALLEST, VALUE_MAX, 7'd0);
      send_request(OP_UNUSED, VALUE_MIN, RANK_W'(SET_CAPACITY));
   endtask

   // Mostly queries with sparse inserts, so the set grows slowly and many
   // depths of search and shift get hit. Switch idling on and off in stretches.
   task automatic test_random_mix();
      for (int i = 0; i < 400; i++) begin
         if (i % 40 == 0) sender_idles = ($urandom_range(0, 3) != 0);
         send_random_item(12);
      end
      sender_idles = 1'b1;
   endtask

   // Insert until the set is full, with queries between the inserts.
   task automatic test_fill_to_capacity();
      while (shadow_set.size() < SET_CAPACITY) begin
         if ($urandom_range(0, 3) == 0) begin
            send_request(($urandom_range(0, 1) != 0) ? OP_SMALLEST : OP_LARGEST,
                         $urandom, pick_rank());
         end else begin
            send_request(OP_INSERT, $urandom, RANK_W'($urandom));
         end
      end
   endtask

   // On the full set: new values get dropped, duplicates pass silently, and
   // every rank up to the capacity selects.
   task automatic test_full_store();
      int roll;
      for (int i = 0; i < 150; i++) begin
         roll = $urandom_range(0, 99);
         if (roll < 35) begin
            send_request(OP_INSERT, pick_value(), RANK_W'($urandom));
         end else if (roll < 60) begin
            send_request(OP_INSERT, shadow_set[$urandom_range(0, shadow_set.size() - 1)],
                         RANK_W'($urandom));
         end else begin
            send_random_item(0);
         end
      end
   endtask

   // Back-to-back transfers with no idling for the last part of the run.
   task automatic test_back_to_back();
      sender_idles = 1'b0;
      for (int i = 0; i < 150; i++) begin
         send_random_item(25);
      end
   endtask

   // Check each response against the oldest owed answer, field by field.
   always @(posedge clock) begin
      answer_type want;
      if (!reset && rsp_valid === 1'b1) begin
         if (awaited_answers.size() == 0) begin
            report_failure("response with nothing outstanding");
         end else begin
            want = awaited_answers.pop_front();
            if (rsp_result_value !== want.value) begin
               report_failure($sformatf("result_value got %0d, want %0d",
                                        rsp_result_value, want.value));
            end
            if (rsp_found !== want.found) begin
               report_failure($sformatf("found got %b, want %b", rsp_found, want.found));
            end
            if (rsp_dropped !== want.dropped) begin
               report_failure($sformatf("dropped got %b, want %b",
                                        rsp_dropped, want.dropped));
            end
            if (want.found) found_seen++;
            if (want.dropped) dropped_seen++;
         end
      end
   end

   // Watchdog: end the run when neither side transfers for too long.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid === 1'b1) begin
         stall_cycles = 0;
      end else begin
         stall_cycles++;
         if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles, %0d responses outstanding",
                     stall_cycles, awaited_answers.size());
            $display("*** FAILED ***");
            $finish;
         end
      end
   end

   initial begin
      repeat (RESET_CYCLES) @(negedge clock);
      reset <= 1'b0;

      test_empty_store();
      test_extreme_values();
      test_random_mix();
      test_fill_to_capacity();
      test_full_store();
      test_back_to_back();

      @(negedge clock);
      start <= 1'b0;

      // Drain: wait for every owed response, then watch for strays.
      while (awaited_answers.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d items (%0d inserts); %0d selections found, %0d inserts dropped.",
               items_sent, inserts_sent, found_seen, dropped_seen);
      $display("Set filled to %0d of %0d entries; %0d mismatches.",
               shadow_set.size(), SET_CAPACITY, error_count);
      if (error_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
